/* src/owsm_pkg.sv */
// Shared constants and types for the omni wheel speed mixer.
// No dependencies; used by owsm_scale and omni_wheel_speed_mixer.
package owsm_pkg;

  localparam int unsigned MIX_K      = 23170;  // sqrt(2)/2, unsigned Q1.15
  localparam int unsigned DIV_STEPS  = 30;
  localparam int unsigned SQRT_STEPS = 15;
  localparam int unsigned SCALE_LAT  = DIV_STEPS + SQRT_STEPS;

  localparam logic [14:0] MAX_SPEED_RST  = 15'd32767;
  localparam logic [14:0] MAX_ROTATE_RST = 15'd32767;
  localparam logic [15:0] RADIUS_RST     = 16'd256;

  typedef enum logic [1:0] {
    CFG_MAX_SPEED   = 2'd0,
    CFG_MAX_ROTATE  = 2'd1,
    CFG_TREAD_RADIUS = 2'd2
  } cfg_idx_t;

endpackage

/* src/owsm_scale.sv */
// Pipelined magnitude scaler: root = floor(sqrt(floor(num / den))), one step per stage.
// 30 restoring divide stages followed by 15 square root stages. Uses owsm_pkg.
module owsm_scale (
  input  logic        clk,
  input  logic [59:0] num_i,
  input  logic [31:0] den_i,
  output logic [14:0] root_o
);

  logic [31:0] drem_r [owsm_pkg::DIV_STEPS];
  logic [29:0] dq_r   [owsm_pkg::DIV_STEPS];
  logic [31:0] dden_r [owsm_pkg::DIV_STEPS];

  logic [17:0] srem_r  [owsm_pkg::SQRT_STEPS];
  logic [14:0] sroot_r [owsm_pkg::SQRT_STEPS];
  logic [29:0] sbits_r [owsm_pkg::SQRT_STEPS];

  // quotient fits 30 bits since num <= max^2 * r2, so the top 30 bits start below den
  for (genvar g = 0; g < owsm_pkg::DIV_STEPS; g++) begin : g_div
    logic [31:0] pr;
    logic [29:0] pq;
    logic [31:0] pd;
    logic [32:0] t;
    logic        ge;
    if (g == 0) begin : g_first
      assign pr = {2'b00, num_i[59:30]};
      assign pq = num_i[29:0];
      assign pd = den_i;
    end else begin : g_next
      assign pr = drem_r[g-1];
      assign pq = dq_r[g-1];
      assign pd = dden_r[g-1];
    end
    assign t  = {pr, pq[29]};
    assign ge = (t >= {1'b0, pd});
    always_ff @(posedge clk) begin
      drem_r[g] <= ge ? 32'(t - {1'b0, pd}) : t[31:0];
      dq_r[g]   <= {pq[28:0], ge};
      dden_r[g] <= pd;
    end
  end

  for (genvar h = 0; h < owsm_pkg::SQRT_STEPS; h++) begin : g_sqrt
    logic [17:0] pr;
    logic [14:0] proot;
    logic [29:0] pb;
    logic [19:0] t;
    logic [19:0] trial;
    logic        ge;
    if (h == 0) begin : g_first
      assign pr    = '0;
      assign proot = '0;
      assign pb    = dq_r[owsm_pkg::DIV_STEPS-1];
    end else begin : g_next
      assign pr    = srem_r[h-1];
      assign proot = sroot_r[h-1];
      assign pb    = sbits_r[h-1];
    end
    assign t     = {pr, pb[29:28]};
    assign trial = {3'b000, proot, 2'b01};
    assign ge    = (t >= trial);
    always_ff @(posedge clk) begin
      srem_r[h]  <= ge ? 18'(t - trial) : t[17:0];
      sroot_r[h] <= {proot[13:0], ge};
      sbits_r[h] <= {pb[27:0], 2'b00};
    end
  end

  assign root_o = sroot_r[owsm_pkg::SQRT_STEPS-1];

endmodule

/* src/omni_wheel_speed_mixer.sv */
// Top level of the four wheel omni mixer: limits, scaling pipeline and wheel mix.
// Depends on owsm_pkg and owsm_scale.
//
// A command is taken in every cycle in which start is high; busy is always low.
// Each command gives one result, marked by out_valid for one cycle, after it
// passes limiting and squaring (stages 0 to 2), the magnitude scaler (30
// divide steps then 15 square root steps, one per stage), and wheel mixing
// and saturation (stages 3 to 5). Results leave in order and cannot be held
// off. Configuration writes take effect at once; the user must make them while
// no command is in flight, as the block itself does not enforce this.
module omni_wheel_speed_mixer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_speed_x,
  input  logic signed [15:0] in_speed_y,
  input  logic signed [15:0] in_rotate_rate,
  output logic               out_valid,
  output logic signed [23:0] out_wheel_front,
  output logic signed [23:0] out_wheel_left,
  output logic signed [23:0] out_wheel_back,
  output logic signed [23:0] out_wheel_right,
  output logic               out_speed_limited,
  output logic               out_rotate_limited,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  typedef struct packed {
    logic               sl;
    logic               rl;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [31:0] rd;
  } side_t;

  localparam int unsigned LAT = owsm_pkg::SCALE_LAT;

  logic [14:0] max_speed_r, max_rotate_r;
  logic [15:0] radius_r;
  logic [29:0] lim2_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r  <= owsm_pkg::MAX_SPEED_RST;
      max_rotate_r <= owsm_pkg::MAX_ROTATE_RST;
      radius_r     <= owsm_pkg::RADIUS_RST;
    end else if (cfg_we) begin
      unique case (owsm_pkg::cfg_idx_t'(cfg_index))
        owsm_pkg::CFG_MAX_SPEED:    max_speed_r  <= cfg_data[14:0];
        owsm_pkg::CFG_MAX_ROTATE:   max_rotate_r <= cfg_data[14:0];
        owsm_pkg::CFG_TREAD_RADIUS: radius_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lim2_r <= 30'(max_speed_r * max_speed_r);
  end

  assign busy = 1'b0;

  // stage 0: capture and clamp rate
  logic               s0_v_r;
  logic signed [15:0] s0_x_r, s0_y_r, s0_d_r;
  logic               s0_rl_r;
  logic signed [16:0] rmax_pos, rmax_neg;
  logic signed [15:0] d_nxt;
  logic               rl_nxt;

  always_comb begin
    rmax_pos = $signed({2'b00, max_rotate_r});
    rmax_neg = -rmax_pos;
    d_nxt    = in_rotate_rate;
    rl_nxt   = 1'b0;
    if (17'(in_rotate_rate) > rmax_pos) begin
      d_nxt  = rmax_pos[15:0];
      rl_nxt = 1'b1;
    end else if (17'(in_rotate_rate) < rmax_neg) begin
      d_nxt  = rmax_neg[15:0];
      rl_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else        s0_v_r <= start && !busy;
    s0_x_r  <= in_speed_x;
    s0_y_r  <= in_speed_y;
    s0_d_r  <= d_nxt;
    s0_rl_r <= rl_nxt;
  end

  // stage 1: squares and products
  logic               s1_v_r;
  logic [31:0]        s1_xx_r, s1_yy_r;
  logic [30:0]        s1_px_r, s1_py_r;
  logic signed [31:0] s1_rd_r;
  logic signed [15:0] s1_x_r, s1_y_r;
  logic               s1_rl_r;
  logic [15:0]        ax, ay;

  assign ax = s0_x_r[15] ? 16'(-s0_x_r) : s0_x_r;
  assign ay = s0_y_r[15] ? 16'(-s0_y_r) : s0_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else        s1_v_r <= s0_v_r;
    s1_xx_r <= 32'(ax * ax);
    s1_yy_r <= 32'(ay * ay);
    s1_px_r <= 31'(max_speed_r * ax);
    s1_py_r <= 31'(max_speed_r * ay);
    s1_rd_r <= 32'($signed({1'b0, radius_r}) * s0_d_r);
    s1_x_r  <= s0_x_r;
    s1_y_r  <= s0_y_r;
    s1_rl_r <= s0_rl_r;
  end

  // stage 2: magnitude, limit check, numerators
  logic        s2_v_r;
  logic [31:0] s2_r2_r;
  logic [59:0] s2_nx_r, s2_ny_r;
  side_t       s2_side_r;
  logic [31:0] r2;

  assign r2 = s1_xx_r + s1_yy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else        s2_v_r <= s1_v_r;
    s2_r2_r      <= r2;
    s2_nx_r      <= 60'(s1_px_r[29:0] * s1_px_r[29:0]);
    s2_ny_r      <= 60'(s1_py_r[29:0] * s1_py_r[29:0]);
    s2_side_r.sl <= (r2 > {2'b00, lim2_r});
    s2_side_r.rl <= s1_rl_r;
    s2_side_r.x  <= s1_x_r;
    s2_side_r.y  <= s1_y_r;
    s2_side_r.rd <= s1_rd_r;
  end

  logic [14:0] mx, my;

  owsm_scale u_scale_x (.clk(clk), .num_i(s2_nx_r), .den_i(s2_r2_r), .root_o(mx));
  owsm_scale u_scale_y (.clk(clk), .num_i(s2_ny_r), .den_i(s2_r2_r), .root_o(my));

  logic  line_v_r    [LAT];
  side_t line_side_r [LAT];

  always_ff @(posedge clk) begin
    for (int i = 0; i < LAT; i++) begin
      if (!rst_n)      line_v_r[i] <= 1'b0;
      else if (i == 0) line_v_r[i] <= s2_v_r;
      else             line_v_r[i] <= line_v_r[i-1];
    end
    line_side_r[0] <= s2_side_r;
    for (int i = 1; i < LAT; i++) line_side_r[i] <= line_side_r[i-1];
  end

  side_t lside;
  assign lside = line_side_r[LAT-1];

  // stage 3: apply scaling, form wheel sums
  logic               s3_v_r;
  logic signed [17:0] s3_s_r [4];
  logic signed [31:0] s3_rd_r;
  logic               s3_sl_r, s3_rl_r;
  logic signed [16:0] xl, yl;

  always_comb begin
    if (lside.sl) begin
      xl = lside.x[15] ? -$signed({2'b00, mx}) : $signed({2'b00, mx});
      yl = lside.y[15] ? -$signed({2'b00, my}) : $signed({2'b00, my});
    end else begin
      xl = 17'(lside.x);
      yl = 17'(lside.y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else        s3_v_r <= line_v_r[LAT-1];
    s3_s_r[0] <= 18'(yl) - 18'(xl);
    s3_s_r[1] <= -18'(xl) - 18'(yl);
    s3_s_r[2] <= 18'(xl) - 18'(yl);
    s3_s_r[3] <= 18'(xl) + 18'(yl);
    s3_rd_r   <= lside.rd;
    s3_sl_r   <= lside.sl;
    s3_rl_r   <= lside.rl;
  end

  // stage 4: K products
  logic               s4_v_r;
  logic signed [33:0] s4_k_r [4];
  logic signed [31:0] s4_rd_r;
  logic               s4_sl_r, s4_rl_r;
  logic signed [15:0] kmix;

  assign kmix = 16'(owsm_pkg::MIX_K);

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else        s4_v_r <= s3_v_r;
    for (int i = 0; i < 4; i++) s4_k_r[i] <= 34'(kmix * s3_s_r[i]);
    s4_rd_r <= s3_rd_r;
    s4_sl_r <= s3_sl_r;
    s4_rl_r <= s3_rl_r;
  end

  // stage 5: add rotation term, round, saturate
  logic signed [23:0] wheel_nxt [4];
  logic signed [39:0] v      [4];
  logic signed [24:0] q      [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      v[i] = 40'(s4_k_r[i]) + (40'(s4_rd_r) <<< 7) + 40'sd16384;
      q[i] = 25'(v[i] >>> 15);
      if (q[i] > 25'sd8388607)       wheel_nxt[i] = 24'sd8388607;
      else if (q[i] < -25'sd8388608) wheel_nxt[i] = -24'sd8388608;
      else                           wheel_nxt[i] = q[i][23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= s4_v_r;
    out_wheel_front    <= wheel_nxt[0];
    out_wheel_left     <= wheel_nxt[1];
    out_wheel_back     <= wheel_nxt[2];
    out_wheel_right    <= wheel_nxt[3];
    out_speed_limited  <= s4_sl_r;
    out_rotate_limited <= s4_rl_r;
  end

  a_start_enters: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> s0_v_r)
    else $error("accepted transaction did not enter pipeline");

  a_rate_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    s0_v_r && s0_rl_r |-> (17'(s0_d_r) == rmax_pos) || (17'(s0_d_r) == rmax_neg))
    else $error("clamped rate not at limit");

  a_scaled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_v_r[LAT-1] && lside.sl |-> (mx <= max_speed_r) && (my <= max_speed_r))
    else $error("scaled component above max speed");

  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |=> ##1 out_valid)
    else $error("result strobe lost");

endmodule
